// ----- hw/rtl/cartridge_bank_mapper_irq_assert.svh -----
// Assertion macros for the cartridge bank mapper.
// Used by cartridge_bank_mapper_irq.sv; no other dependencies.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH

// same-cycle implication
`define CBMI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbmi assertion failed");

// next-cycle implication
`define CBMI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbmi assertion failed");

`endif

// ----- hw/rtl/cbmi_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by all cbmi modules and the top level.
package cbmi_pkg;

	localparam int PRG_ADDR_BITS_DEF = 22;
	localparam int PHYS_W = 22;
	localparam int CHR_W = 19;

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_READ_PRG = 2'd2,
		CMD_READ_CHR = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [8:0]  scanline;
		logic        rendering_enabled;
	} req_t;

	typedef struct packed {
		logic [PHYS_W-1:0] phys_addr;
		logic              mapped;
		logic              irq_pulse;
		logic              mirror_select;
	} rsp_t;

	// configuration register indexes
	localparam logic CFG_PRG_MASK = 1'b0;
	localparam logic CFG_CHR_MASK = 1'b1;

	localparam logic [PHYS_W-1:0] PRG_MASK_RESET = 22'h3F_FFFF;
	localparam logic [CHR_W-1:0]  CHR_MASK_RESET = 19'h7_FFFF;

	// register map
	localparam logic [15:0] REG_MIRROR_PRG0 = 16'h8000;
	localparam logic [15:0] REG_PRG1        = 16'h8001;
	localparam logic [15:0] REG_CHR0        = 16'h8002;
	localparam logic [15:0] REG_CHR1        = 16'h8003;
	localparam logic [15:0] REG_CHR2        = 16'hA000;
	localparam logic [15:0] REG_CHR3        = 16'hA001;
	localparam logic [15:0] REG_CHR4        = 16'hA002;
	localparam logic [15:0] REG_CHR5        = 16'hA003;
	localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_ENABLE  = 16'hC002;
	localparam logic [15:0] REG_IRQ_DISABLE = 16'hC003;

	localparam int MIRROR_BIT = 6;

	// program windows
	localparam logic [15:0] PRG_FIXED_BASE = 16'hC000;
	localparam logic [15:0] PRG_BANK1_BASE = 16'hA000;
	localparam logic [15:0] PRG_BANK0_BASE = 16'h8000;
	localparam logic [7:0]  FIXED_BANK16   = 8'hFF;

	// pattern windows
	localparam logic [15:0] CHR_1K_BASE = 16'h1000;
	localparam logic [15:0] CHR_END     = 16'h2000;

	localparam logic [8:0] IRQ_FIRST_LINE = 9'd21;
	localparam logic [8:0] IRQ_LAST_LINE  = 9'd260;

endpackage

// ----- hw/rtl/cartridge_bank_mapper_irq.sv -----
// Top level of the cartridge bank mapper with scanline interrupt.
// Depends on cbmi_pkg, cbmi_xlate, cbmi_irq and cartridge_bank_mapper_irq_assert.svh.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one command per
//   transaction: register write, scanline tick, program read or pattern read.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns exactly one result
//   per request: translated address, mapped flag, interrupt pulse and the
//   current mirroring bit (after any write of that same request).
//   Each request accepted at an edge has its result in the output register
//   after that edge. Throughput is one transaction per cycle while the
//   receiver does not stall; decode, bank lookup and counter update are a
//   single combinational pass ahead of the output register.
//   When the receiver stalls, the held result stays put and req_stall rises
//   only while that result is still waiting; a new request is taken in the
//   same cycle the held result leaves.
//   cfg_we/cfg_index/cfg_data write the program and pattern size masks;
//   write them only while the block is idle.
//   Reset clears all bank, interrupt and handshake state and sets both masks
//   to all ones; the block is ready for a request once reset is released.
`include "cartridge_bank_mapper_irq_assert.svh"
module cartridge_bank_mapper_irq #(
	parameter int PRG_ADDR_BITS = cbmi_pkg::PRG_ADDR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [cbmi_pkg::PHYS_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  cbmi_pkg::req_t              req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output cbmi_pkg::rsp_t              rsp_data
);
	import cbmi_pkg::*;

	logic [PHYS_W-1:0] prg_mask_q;
	logic [CHR_W-1:0]  chr_mask_q;
	logic [1:0][5:0]   prg_bank_q;
	logic [5:0][7:0]   chr_bank_q;
	logic              mirror_q;
	logic              mirror_d;
	logic              accept;
	logic              is_write;
	logic [PHYS_W-1:0] phys;
	logic              mapped;
	logic              irq_pulse;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign is_write  = accept && (req_data.cmd == CMD_WRITE);
	assign mirror_d  = (is_write && req_data.address == REG_MIRROR_PRG0)
		? req_data.write_data[MIRROR_BIT] : mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q <= PRG_MASK_RESET;
			chr_mask_q <= CHR_MASK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRG_MASK: prg_mask_q <= cfg_data;
				CFG_CHR_MASK: chr_mask_q <= cfg_data[CHR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_q <= '0;
			chr_bank_q <= '0;
			mirror_q   <= 1'b0;
		end else if (is_write) begin
			mirror_q <= mirror_d;
			unique case (req_data.address)
				REG_MIRROR_PRG0: prg_bank_q[0] <= req_data.write_data[5:0];
				REG_PRG1:        prg_bank_q[1] <= req_data.write_data[5:0];
				REG_CHR0:        chr_bank_q[0] <= req_data.write_data;
				REG_CHR1:        chr_bank_q[1] <= req_data.write_data;
				REG_CHR2:        chr_bank_q[2] <= req_data.write_data;
				REG_CHR3:        chr_bank_q[3] <= req_data.write_data;
				REG_CHR4:        chr_bank_q[4] <= req_data.write_data;
				REG_CHR5:        chr_bank_q[5] <= req_data.write_data;
				default: ;
			endcase
		end
	end

	cbmi_xlate #(
		.PRG_ADDR_BITS(PRG_ADDR_BITS)
	) u_xlate (
		.req       (req_data),
		.prg_bank  (prg_bank_q),
		.chr_bank  (chr_bank_q),
		.prg_mask  (prg_mask_q),
		.chr_mask  (chr_mask_q),
		.phys_addr (phys),
		.mapped    (mapped)
	);

	cbmi_irq u_irq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req_data),
		.irq_pulse (irq_pulse)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.phys_addr     <= phys;
			rsp_q.mapped        <= mapped;
			rsp_q.irq_pulse     <= irq_pulse;
			rsp_q.mirror_select <= mirror_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`CBMI_ASSERT_NXT(a_req_gives_rsp, clk, arst_n, accept, rsp_valid)
	`CBMI_ASSERT_NXT(a_no_irq_off_tick, clk, arst_n,
		accept && req_data.cmd != CMD_TICK, !rsp_data.irq_pulse)
	`CBMI_ASSERT_NXT(a_no_map_on_ctrl, clk, arst_n,
		accept && (req_data.cmd == CMD_WRITE || req_data.cmd == CMD_TICK),
		!rsp_data.mapped && rsp_data.phys_addr == '0)
	`CBMI_ASSERT_IMP(a_unmapped_zero, clk, arst_n,
		rsp_valid && !rsp_data.mapped, rsp_data.phys_addr == '0)

endmodule

// ----- hw/rtl/cbmi_xlate.sv -----
// Program and pattern address translation for the bank mapper.
// Depends on cbmi_pkg. Purely combinational.
module cbmi_xlate #(
	parameter int PRG_ADDR_BITS = cbmi_pkg::PRG_ADDR_BITS_DEF
) (
	input  cbmi_pkg::req_t                        req,
	input  logic [1:0][5:0]                       prg_bank,
	input  logic [5:0][7:0]                       chr_bank,
	input  logic [cbmi_pkg::PHYS_W-1:0]           prg_mask,
	input  logic [cbmi_pkg::CHR_W-1:0]            chr_mask,
	output logic [cbmi_pkg::PHYS_W-1:0]           phys_addr,
	output logic                                  mapped
);
	import cbmi_pkg::*;

	logic [PHYS_W-1:0]        prg_full;
	logic                     prg_hit;
	logic [PRG_ADDR_BITS-1:0] prg_phys;
	logic [CHR_W-1:0]         chr_full;
	logic                     chr_hit;
	logic [2:0]               chr_1k_idx;
	logic [15:0]              a;

	assign a = req.address;
	assign chr_1k_idx = 3'd2 + {1'b0, a[11:10]};

	always_comb begin
		prg_full = '0;
		prg_hit  = 1'b0;
		if (a >= PRG_FIXED_BASE) begin
			prg_full = {FIXED_BANK16, a[13:0]};
			prg_hit  = 1'b1;
		end else if (a >= PRG_BANK1_BASE) begin
			prg_full = {3'b000, prg_bank[1], a[12:0]};
			prg_hit  = 1'b1;
		end else if (a >= PRG_BANK0_BASE) begin
			prg_full = {3'b000, prg_bank[0], a[12:0]};
			prg_hit  = 1'b1;
		end
	end

	assign prg_phys = prg_full[PRG_ADDR_BITS-1:0] & prg_mask[PRG_ADDR_BITS-1:0];

	always_comb begin
		chr_full = '0;
		chr_hit  = 1'b0;
		if (a < CHR_1K_BASE) begin
			chr_full = {chr_bank[{2'b00, a[11]}], a[10:0]};
			chr_hit  = 1'b1;
		end else if (a < CHR_END) begin
			chr_full = {1'b0, chr_bank[chr_1k_idx], a[9:0]};
			chr_hit  = 1'b1;
		end
	end

	always_comb begin
		unique case (req.cmd)
			CMD_READ_PRG: begin
				phys_addr = PHYS_W'(prg_phys);
				mapped    = prg_hit;
			end
			CMD_READ_CHR: begin
				phys_addr = {3'b000, chr_full & chr_mask};
				mapped    = chr_hit;
			end
			default: begin
				phys_addr = '0;
				mapped    = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/cbmi_irq.sv -----
// Scanline interrupt counter with latch, reload flag and enable.
// Depends on cbmi_pkg.
module cbmi_irq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  cbmi_pkg::req_t req,
	output logic           irq_pulse
);
	import cbmi_pkg::*;

	logic [7:0] count_q;
	logic [7:0] latch_q;
	logic       pending_q;
	logic       on_q;
	logic       tick_en;
	logic       reload;
	logic [7:0] count_d;

	assign tick_en = accept && (req.cmd == CMD_TICK) && on_q && req.rendering_enabled
		&& (req.scanline >= IRQ_FIRST_LINE) && (req.scanline <= IRQ_LAST_LINE);
	assign reload    = (count_q == 8'd0) || pending_q;
	assign count_d   = reload ? latch_q : count_q - 8'd1;
	assign irq_pulse = tick_en && (count_d == 8'd0) && (count_q != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			latch_q   <= '0;
			pending_q <= 1'b0;
			on_q      <= 1'b0;
		end else if (accept && req.cmd == CMD_WRITE) begin
			unique case (req.address)
				REG_IRQ_LATCH:   latch_q   <= req.write_data;
				REG_IRQ_RELOAD:  pending_q <= 1'b1;
				REG_IRQ_ENABLE:  on_q      <= 1'b1;
				REG_IRQ_DISABLE: on_q      <= 1'b0;
				default: ;
			endcase
		end else if (tick_en) begin
			count_q <= count_d;
			if (reload) pending_q <= 1'b0;
		end
	end

endmodule

// ----- bench/cartridge_bank_mapper_irq_checker.sv -----
// Checker for cartridge_bank_mapper_irq: watches the config, req and rsp channels,
// predicts each result from its own copy of bank, mask and interrupt state, and compares.
// Depends on cbmi_pkg.
module cartridge_bank_mapper_irq_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [cbmi_pkg::PHYS_W-1:0] cfg_data,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  cbmi_pkg::req_t              req_data,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  cbmi_pkg::rsp_t              rsp_data,
	output int                          fail_count,
	output int                          pending
);
	import cbmi_pkg::*;

	logic [PHYS_W-1:0] prg_mask;
	logic [CHR_W-1:0]  chr_mask;
	logic [5:0]        prg_bank_q [2];
	logic [7:0]        chr_bank_q [6];
	logic              mirror_q;
	logic [7:0]        irq_count;
	logic [7:0]        irq_latch;
	logic              reload_req;
	logic              irq_en;

	rsp_t bus_results_q[$];
	rsp_t want;
	int   n_fail = 0;

	assign fail_count = n_fail;

	function automatic rsp_t mapper_result(req_t r);
		rsp_t              o;
		logic [PHYS_W-1:0] phys;
		logic [7:0]        prior;
		int                idx;
		o = '0;
		phys = '0;
		case (r.cmd)
			CMD_WRITE: begin
				case (r.address)
					REG_MIRROR_PRG0: begin
						mirror_q = r.write_data[MIRROR_BIT];
						prg_bank_q[0] = r.write_data[5:0];
					end
					REG_PRG1:        prg_bank_q[1] = r.write_data[5:0];
					REG_CHR0:        chr_bank_q[0] = r.write_data;
					REG_CHR1:        chr_bank_q[1] = r.write_data;
					REG_CHR2:        chr_bank_q[2] = r.write_data;
					REG_CHR3:        chr_bank_q[3] = r.write_data;
					REG_CHR4:        chr_bank_q[4] = r.write_data;
					REG_CHR5:        chr_bank_q[5] = r.write_data;
					REG_IRQ_LATCH:   irq_latch = r.write_data;
					REG_IRQ_RELOAD:  reload_req = 1'b1;
					REG_IRQ_ENABLE:  irq_en = 1'b1;
					REG_IRQ_DISABLE: irq_en = 1'b0;
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (r.scanline >= IRQ_FIRST_LINE && r.scanline <= IRQ_LAST_LINE &&
				    irq_en && r.rendering_enabled) begin
					prior = irq_count;
					if (irq_count == 8'd0 || reload_req) begin
						reload_req = 1'b0;
						irq_count = irq_latch;
					end else begin
						irq_count = irq_count - 8'd1;
					end
					o.irq_pulse = (irq_count == 8'd0) && (prior != 8'd0);
				end
			end
			CMD_READ_PRG: begin
				if (r.address >= PRG_FIXED_BASE) begin
					phys = {FIXED_BANK16, r.address[13:0]};
					o.mapped = 1'b1;
				end else if (r.address >= PRG_BANK1_BASE) begin
					phys = {3'b0, prg_bank_q[1], r.address[12:0]};
					o.mapped = 1'b1;
				end else if (r.address >= PRG_BANK0_BASE) begin
					phys = {3'b0, prg_bank_q[0], r.address[12:0]};
					o.mapped = 1'b1;
				end
				o.phys_addr = phys & prg_mask;
			end
			default: begin
				if (r.address < CHR_1K_BASE) begin
					phys = {3'b0, chr_bank_q[r.address[11]], r.address[10:0]};
					o.mapped = 1'b1;
				end else if (r.address < CHR_END) begin
					idx = 2 + r.address[11:10];
					phys = {4'b0, chr_bank_q[idx], r.address[9:0]};
					o.mapped = 1'b1;
				end
				o.phys_addr = phys & {3'b0, chr_mask};
			end
		endcase
		o.mirror_select = mirror_q;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [PHYS_W-1:0] exp_v,
	                           input logic [PHYS_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			n_fail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask <= PRG_MASK_RESET;
			chr_mask <= CHR_MASK_RESET;
			for (int i = 0; i < 2; i++) prg_bank_q[i] = '0;
			for (int i = 0; i < 6; i++) chr_bank_q[i] = '0;
			mirror_q = 1'b0;
			irq_count = '0;
			irq_latch = '0;
			reload_req = 1'b0;
			irq_en = 1'b0;
			bus_results_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_PRG_MASK)
					prg_mask <= cfg_data;
				else
					chr_mask <= cfg_data[CHR_W-1:0];
			end
			if (rsp_valid && !rsp_stall) begin
				if (bus_results_q.size() == 0) begin
					$display("%0t: rsp transaction with nothing outstanding, actual %h",
					         $time, rsp_data);
					n_fail++;
				end else begin
					want = bus_results_q.pop_front();
					check_field("phys_addr", want.phys_addr, rsp_data.phys_addr);
					check_field("mapped", PHYS_W'(want.mapped), PHYS_W'(rsp_data.mapped));
					check_field("irq_pulse", PHYS_W'(want.irq_pulse),
					            PHYS_W'(rsp_data.irq_pulse));
					check_field("mirror_select", PHYS_W'(want.mirror_select),
					            PHYS_W'(rsp_data.mirror_select));
				end
			end
			if (req_valid && !req_stall)
				bus_results_q.push_back(mapper_result(req_data));
			pending <= bus_results_q.size();
		end
	end

endmodule

// ----- bench/cartridge_bank_mapper_irq_tb.sv -----
// Testbench top for cartridge_bank_mapper_irq: directed and random bus transactions
// under several size-mask settings, with random idle and stall bursts.
// Depends on cbmi_pkg, cartridge_bank_mapper_irq and cartridge_bank_mapper_irq_checker.
module cartridge_bank_mapper_irq_tb;
	import cbmi_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 150;
	localparam int REQ_W = $bits(req_t);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_PRG_MASK;
	logic [PHYS_W-1:0] cfg_data = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req_data = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp_data;
	logic              calm = 1'b0;
	int                fail_count;
	int                outstanding;
	int                cycle_count = 0;

	cartridge_bank_mapper_irq u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	cartridge_bank_mapper_irq_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.fail_count (fail_count),
		.pending    (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: stall bursts and free stretches, none while calm
	initial begin
		forever begin
			if (calm) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic req_t mk(cmd_t c, logic [15:0] a, logic [7:0] d, logic [8:0] line,
	                            logic rend);
		req_t r;
		r.cmd = c;
		r.address = a;
		r.write_data = d;
		r.scanline = line;
		r.rendering_enabled = rend;
		return r;
	endfunction

	function automatic logic [15:0] reg_addr(int i);
		case (i)
			0:  return REG_MIRROR_PRG0;
			1:  return REG_PRG1;
			2:  return REG_CHR0;
			3:  return REG_CHR1;
			4:  return REG_CHR2;
			5:  return REG_CHR3;
			6:  return REG_CHR4;
			7:  return REG_CHR5;
			8:  return REG_IRQ_LATCH;
			9:  return REG_IRQ_DISABLE;
			10: return REG_IRQ_ENABLE;
			11: return REG_IRQ_ENABLE;
			default: return REG_IRQ_RELOAD;
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   k;
		r = req_t'(REQ_W'({$urandom, $urandom}));
		k = $urandom_range(0, 9);
		if (k < 3) begin
			r.cmd = CMD_WRITE;
			if ($urandom_range(0, 9) != 0)
				r.address = reg_addr($urandom_range(0, 13));
			if (r.address == REG_IRQ_LATCH && $urandom_range(0, 1) == 0)
				r.write_data = 8'($urandom_range(0, 4));
		end else if (k < 6) begin
			r.cmd = CMD_TICK;
			r.scanline = 9'($urandom_range(0, IRQ_LAST_LINE + 1));
			if ($urandom_range(0, 4) != 0) begin
				r.scanline = 9'($urandom_range(IRQ_FIRST_LINE, IRQ_LAST_LINE));
				r.rendering_enabled = 1'b1;
			end
		end else if (k < 8) begin
			r.cmd = CMD_READ_PRG;
		end else begin
			r.cmd = CMD_READ_CHR;
			if ($urandom_range(0, 3) != 0)
				r.address = 16'($urandom_range(0, CHR_END - 1));
		end
		return r;
	endfunction

	task automatic push(input req_t r);
		req_data <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic idle(input int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_masks(input logic [PHYS_W-1:0] prg, input logic [CHR_W-1:0] chr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRG_MASK;
		cfg_data <= prg;
		@(posedge clk);
		cfg_index <= CFG_CHR_MASK;
		cfg_data <= {3'b0, chr};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_masks(PRG_MASK_RESET, CHR_MASK_RESET);

		// bank registers, window edges, unbanked reads
		push(mk(CMD_WRITE, REG_MIRROR_PRG0, 8'hFF, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_PRG1, 8'h2A, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_CHR0, 8'hFF, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_CHR1, 8'h01, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_CHR2, 8'h80, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_CHR5, 8'h55, 9'd0, 1'b0));
		push(mk(CMD_READ_PRG, 16'h7FFF, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_PRG, 16'h8000, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_PRG, 16'hBFFF, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_PRG, 16'hC000, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_PRG, 16'hFFFF, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_CHR, 16'h0000, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_CHR, 16'h0FFF, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_CHR, 16'h1000, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_CHR, 16'h1FFF, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_READ_CHR, 16'h2000, 8'h00, 9'd0, 1'b0));
		// counter: reload, fall to zero, ignored ticks, zero latch reload from nonzero
		push(mk(CMD_WRITE, REG_IRQ_LATCH, 8'h01, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_IRQ_ENABLE, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_TICK, 16'h0000, 8'h00, IRQ_FIRST_LINE, 1'b1));
		push(mk(CMD_TICK, 16'h0000, 8'h00, IRQ_LAST_LINE, 1'b1));
		push(mk(CMD_TICK, 16'h0000, 8'h00, IRQ_FIRST_LINE - 9'd1, 1'b1));
		push(mk(CMD_TICK, 16'h0000, 8'h00, IRQ_LAST_LINE + 9'd1, 1'b1));
		push(mk(CMD_TICK, 16'h0000, 8'h00, 9'd50, 1'b0));
		push(mk(CMD_TICK, 16'h0000, 8'h00, 9'd50, 1'b1));
		push(mk(CMD_WRITE, REG_IRQ_LATCH, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_WRITE, REG_IRQ_RELOAD, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_TICK, 16'h0000, 8'h00, 9'd50, 1'b1));
		push(mk(CMD_WRITE, REG_IRQ_DISABLE, 8'h00, 9'd0, 1'b0));
		push(mk(CMD_TICK, 16'h0000, 8'h00, 9'd50, 1'b1));

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: set_masks('0, '0);
				1: set_masks(PHYS_W'($urandom), CHR_W'($urandom));
				2: set_masks(22'h01_FFFF, 19'h0_1FFF);
				3: set_masks(22'h00_7FFF, 19'h3_FFFF);
				default: set_masks(PRG_MASK_RESET, CHR_MASK_RESET);
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 50 == 0)
					calm <= (ph == 4) || ($urandom_range(0, 3) == 0);
				push(rand_req());
				if (!calm && ph != 4 && $urandom_range(0, 3) == 0)
					idle($urandom_range(1, 16));
			end
		end

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/cbmi_pkg.sv
hw/rtl/cbmi_xlate.sv
hw/rtl/cbmi_irq.sv
hw/rtl/cartridge_bank_mapper_irq.sv
bench/cartridge_bank_mapper_irq_checker.sv
bench/cartridge_bank_mapper_irq_tb.sv
